>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk_i and gated by rst_ni
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property that must hold at every clock edge out of reset
`define GBE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// overlapping implication
`define GBE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GBE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/gbe_pkg.sv
// ----------------------------------------------------------------------------
// gap buffer editor package
// sizes, field widths and command and status codes
// ----------------------------------------------------------------------------
package gbe_pkg;

  localparam int CAPACITY   = 1024;
  localparam int CHAR_WIDTH = 8;

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int MARK_W = $clog2(CAPACITY + 1);

  // stream field widths
  localparam int CMD_W   = 2;
  localparam int CHR_W   = 8;
  localparam int AMT_W   = 12;
  localparam int STAT_W  = 2;
  localparam int POS_W   = 11;

  localparam int IN_DATA_W  = ((CHR_W + AMT_W + 7) / 8) * 8;
  localparam int IN_PAD_W   = IN_DATA_W - CHR_W - AMT_W;
  localparam int OUT_DATA_W = ((3 * POS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - 3 * POS_W;

  // compare width for clamping a move amount against a mark
  localparam int CMP_W = ((AMT_W > MARK_W) ? AMT_W : MARK_W) + 1;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MOVE   = 2'd2;

  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_START = 2'd2;

endpackage

>>> design/gap_buffer_editor.sv
// ----------------------------------------------------------------------------
// gap buffer editor
// fixed-capacity text store with a movable gap at the cursor
// ----------------------------------------------------------------------------
// Insert, delete, a move that clamps to zero characters and an unknown
// command each finish in their cycle of acceptance, and their result word is
// presented from the next cycle. A move of n characters copies them across
// the gap one per cycle through the single-port-read, single-port-write text
// memory. It keeps the input not ready through the copy, and its result word is
// registered after the copy once the output is free. A new word is also held
// off while a result waits unread at the output. The text memory has no reset
// and no clearing pass: positions are always written before they are read.
`include "assert_macros.svh"

module gap_buffer_editor import gbe_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // char_value, move_amount, pad
  input  logic [CMD_W-1:0]      s_axis_tuser,   // command
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // cursor_position, gap_size, moved_count, pad
  output logic [STAT_W-1:0]     m_axis_tuser    // status
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MOVE = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [MARK_W-1:0] CAP_MARK = MARK_W'(CAPACITY);

  logic [1:0]        state_q, state_d;
  logic [MARK_W-1:0] gs_q, gs_d, ge_q, ge_d;
  logic [MARK_W-1:0] rd_cnt_q, rd_cnt_d;
  logic              pend_q, pend_d;
  logic              dir_q, dir_d;          // 1: gap moves left
  logic [MARK_W-1:0] n_q, n_d;
  logic [ADDR_W-1:0] src_q, src_d, dst_q, dst_d;

  logic              out_vld_q, out_vld_d;
  logic [STAT_W-1:0] out_stat_q, out_stat_d;
  logic [POS_W-1:0]  out_cur_q, out_cur_d, out_gap_q, out_gap_d, out_mov_q, out_mov_d;

  logic [CHAR_WIDTH-1:0] mem [CAPACITY];
  logic [CHAR_WIDTH-1:0] rdata_q;
  logic                  mem_we, mem_re;
  logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
  logic [CHAR_WIDTH-1:0] mem_wdata;

  logic              accept, out_free;
  logic [CMD_W-1:0]  cmd;
  logic [CHR_W-1:0]  chr;
  logic [AMT_W-1:0]  amt;
  logic [CMP_W-1:0]  amt_sx, mag, avail, n_w;
  logic              neg;
  logic [ADDR_W-1:0] src_step, dst_step;

  assign cmd = s_axis_tuser;
  assign chr = s_axis_tdata[CHR_W-1:0];
  assign amt = s_axis_tdata[CHR_W+AMT_W-1:CHR_W];

  assign out_free      = !out_vld_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // clamp the move to the text on that side of the gap
  assign neg    = amt[AMT_W-1];
  assign amt_sx = {{(CMP_W-AMT_W){amt[AMT_W-1]}}, amt};
  assign mag    = neg ? (CMP_W'(0) - amt_sx) : amt_sx;
  assign avail  = neg ? CMP_W'(CAP_MARK - ge_q) : CMP_W'(gs_q);
  assign n_w    = (mag < avail) ? mag : avail;

  // source and destination address steppers for the copy loop, both following dir_q
  assign src_step = dir_q ? (src_q - ADDR_W'(1)) : (src_q + ADDR_W'(1));
  assign dst_step = dir_q ? (dst_q - ADDR_W'(1)) : (dst_q + ADDR_W'(1));

  always_comb begin
    state_d    = state_q;
    gs_d       = gs_q;
    ge_d       = ge_q;
    rd_cnt_d   = rd_cnt_q;
    pend_d     = 1'b0;
    dir_d      = dir_q;
    n_d        = n_q;
    src_d      = src_q;
    dst_d      = dst_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_stat_d = out_stat_q;
    out_cur_d  = out_cur_q;
    out_gap_d  = out_gap_q;
    out_mov_d  = out_mov_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = dst_q;
    mem_raddr  = src_q;
    mem_wdata  = rdata_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_stat_d = STAT_DONE;
          out_mov_d  = '0;
          case (cmd)
            CMD_INSERT: begin
              if (gs_q == ge_q) begin
                out_stat_d = STAT_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = gs_q[ADDR_W-1:0];
                mem_wdata = CHAR_WIDTH'(chr);
                gs_d      = gs_q + MARK_W'(1);
              end
            end
            CMD_DELETE: begin
              if (gs_q != '0) begin
                gs_d = gs_q - MARK_W'(1);
              end else begin
                out_stat_d = STAT_START;
              end
            end
            CMD_MOVE: begin
              if (n_w != '0) begin
                n_d      = MARK_W'(n_w);
                dir_d    = !neg;
                rd_cnt_d = '0;
                src_d    = neg ? ge_q[ADDR_W-1:0] : ADDR_W'(gs_q - MARK_W'(1));
                dst_d    = neg ? gs_q[ADDR_W-1:0] : ADDR_W'(ge_q - MARK_W'(1));
                state_d  = ST_MOVE;
              end
            end
            default: begin
            end
          endcase
          if (!(cmd == CMD_MOVE && n_w != '0)) begin
            out_vld_d = 1'b1;
            out_cur_d = POS_W'(gs_d);
            out_gap_d = POS_W'(ge_d - gs_d);
          end
        end
      end
      ST_MOVE: begin
        // read of the next character overlaps the write of the previous one
        if (rd_cnt_q != n_q) begin
          mem_re   = 1'b1;
          src_d    = src_step;
          rd_cnt_d = rd_cnt_q + MARK_W'(1);
          pend_d   = 1'b1;
        end
        if (pend_q) begin
          mem_we = 1'b1;
          dst_d  = dst_step;
          if (rd_cnt_q == n_q) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          gs_d       = dir_q ? (gs_q - n_q) : (gs_q + n_q);
          ge_d       = dir_q ? (ge_q - n_q) : (ge_q + n_q);
          out_vld_d  = 1'b1;
          out_cur_d  = POS_W'(gs_d);
          out_gap_d  = POS_W'(ge_d - gs_d);
          out_mov_d  = POS_W'(n_q);
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      gs_q      <= '0;
      ge_q      <= CAP_MARK;
      rd_cnt_q  <= '0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      gs_q      <= gs_d;
      ge_q      <= ge_d;
      rd_cnt_q  <= rd_cnt_d;
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dir_q      <= dir_d;
    n_q        <= n_d;
    src_q      <= src_d;
    dst_q      <= dst_d;
    out_stat_q <= out_stat_d;
    out_cur_q  <= out_cur_d;
    out_gap_q  <= out_gap_d;
    out_mov_q  <= out_mov_d;
  end

  // text memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_stat_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_mov_q, out_gap_q, out_cur_q};

  `GBE_ASSERT(a_gap_order, gs_q <= ge_q, "cursor beyond gap end")
  `GBE_ASSERT(a_gap_cap, ge_q <= CAP_MARK, "gap end beyond capacity")
  `GBE_ASSERT_IMP(a_busy_not_ready, state_q != ST_IDLE, !s_axis_tready, "ready while copying")
  `GBE_ASSERT_IMP(a_read_bound, state_q == ST_MOVE, rd_cnt_q <= n_q, "copy read count overrun")
  `GBE_ASSERT_NXT(a_write_follows, state_q == ST_MOVE && mem_re, mem_we,
                  "copied character not written back")

endmodule
